[hdl/gcma_pkg.sv]
// Shared constants, types and state encoding for the greedy makespan assigner.
package gcma_pkg;

  localparam int unsigned NUM_SERVERS = 8;
  localparam int unsigned SRV_W       = 3;
  localparam int unsigned SIU_W       = 4;
  localparam int unsigned LOAD_W      = 40;
  localparam int unsigned WEIGHT_W    = 24;
  localparam int unsigned COST_W      = 24;
  localparam int unsigned FACTOR_W    = 32;
  localparam int unsigned PROD_W      = FACTOR_W + WEIGHT_W;
  localparam int unsigned SCORE_W     = PROD_W + 1;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SERVERS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_FACTOR    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [SIU_W-1:0]    SIU_RESET    = 4'd8;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 32'h0001_0000;

  // Operation codes.
  localparam logic OP_PRELOAD = 1'b0;
  localparam logic OP_PLACE   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  // Sequencer to scoring unit.
  typedef struct packed {
    logic              clear;
    logic              issue;
    logic [SRV_W-1:0]  idx;
    logic [COST_W-1:0] comm;
  } score_req_t;

  // Scoring unit to sequencer.
  typedef struct packed {
    logic             busy;
    logic [SRV_W-1:0] best_idx;
  } score_stat_t;

  // Load charge request to the load file.
  typedef struct packed {
    logic                en;
    logic [SRV_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
  } charge_t;

endpackage

[hdl/gcma_load_file.sv]
// Per-server load registers, current makespan and the saturating charge logic.
module gcma_load_file
  import gcma_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SRV_W-1:0]  rd_idx,
  output logic [LOAD_W-1:0] rd_load,
  input  charge_t           charge,
  output logic [LOAD_W-1:0] makespan
);

  logic [LOAD_W-1:0] load_r [NUM_SERVERS];
  logic [LOAD_W-1:0] makespan_r;
  logic [LOAD_W:0]   sum;
  logic [LOAD_W-1:0] load_nxt;

  // Read port for the scoring unit.
  assign rd_load  = load_r[rd_idx];
  assign makespan = makespan_r;

  // Saturating addition of the charged weight.
  always_comb begin
    sum      = {1'b0, load_r[charge.idx]} + (LOAD_W + 1)'(charge.weight);
    load_nxt = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  end

  // Load and makespan update; the makespan follows the largest load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        load_r[i] <= '0;
      end
      makespan_r <= '0;
    end else if (charge.en) begin
      load_r[charge.idx] <= load_nxt;
      if (load_nxt > makespan_r) begin
        makespan_r <= load_nxt;
      end
    end
  end

endmodule

[hdl/gcma_score_unit.sv]
// Shared three-stage scoring pipeline: slack, weighted overload product, compare.
module gcma_score_unit
  import gcma_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  score_req_t          req,
  input  logic [WEIGHT_W-1:0] weight,
  input  logic [LOAD_W-1:0]   rd_load,
  input  logic [LOAD_W-1:0]   makespan,
  input  logic [FACTOR_W-1:0] cost_factor,
  output score_stat_t         stat
);

  logic [LOAD_W-1:0]   slack;
  logic                over_pos;
  logic [WEIGHT_W-1:0] over_amt;

  logic                v1_r;
  logic [SRV_W-1:0]    idx1_r;
  logic [COST_W-1:0]   comm1_r;
  logic [LOAD_W-1:0]   slack1_r;
  logic                pos1_r;
  logic [WEIGHT_W-1:0] over1_r;

  logic                v2_r;
  logic [SRV_W-1:0]    idx2_r;
  logic [COST_W-1:0]   comm2_r;
  logic [LOAD_W-1:0]   slack2_r;
  logic [PROD_W-1:0]   prod2_r;
  logic [PROD_W-1:0]   prod_nxt;

  logic [SCORE_W-1:0]  cost;
  logic                better;
  logic                have_r;
  logic [SCORE_W-1:0]  best_cost_r;
  logic [LOAD_W-1:0]   best_slack_r;
  logic [SRV_W-1:0]    best_idx_r;

  // Stage one: slack of the server and its overload when positive.
  // Overload is positive only when slack < weight, so it fits the weight width.
  always_comb begin
    slack    = makespan - rd_load;
    over_pos = slack < LOAD_W'(weight);
    over_amt = weight - slack[WEIGHT_W-1:0];
  end

  // Stage two: makespan factor times overload.
  assign prod_nxt = pos1_r ? (PROD_W'(cost_factor) * PROD_W'(over1_r)) : '0;

  // Stage three: total cost; a smaller overload is a larger slack for equal weight.
  always_comb begin
    cost   = SCORE_W'({comm2_r, 16'b0}) + SCORE_W'(prod2_r);
    better = !have_r || (cost < best_cost_r) ||
             ((cost == best_cost_r) && (slack2_r > best_slack_r));
  end

  // Pipeline valid bits and best tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      have_r <= 1'b0;
    end else begin
      v1_r <= req.issue;
      v2_r <= v1_r;
      if (req.clear) begin
        have_r <= 1'b0;
      end else if (v2_r && better) begin
        have_r <= 1'b1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    idx1_r   <= req.idx;
    comm1_r  <= req.comm;
    slack1_r <= slack;
    pos1_r   <= over_pos;
    over1_r  <= over_amt;
    idx2_r   <= idx1_r;
    comm2_r  <= comm1_r;
    slack2_r <= slack1_r;
    prod2_r  <= prod_nxt;
    if (v2_r && better) begin
      best_cost_r  <= cost;
      best_slack_r <= slack2_r;
      best_idx_r   <= idx2_r;
    end
  end

  assign stat.busy     = v1_r | v2_r;
  assign stat.best_idx = best_idx_r;

endmodule

[hdl/gcma_ctrl.sv]
// Sequencer: captures a request, steps the scorer over servers when placing, commits.
module gcma_ctrl
  import gcma_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [ID_W-1:0]     in_item_id,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic [SRV_W-1:0]    in_given_server,
  input  logic [COST_W-1:0]   in_costs [NUM_SERVERS],
  input  logic [SIU_W-1:0]    servers_in_use,
  output score_req_t          req,
  input  score_stat_t         stat,
  output charge_t             charge,
  output logic [WEIGHT_W-1:0] weight,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     out_result_id,
  output logic [SRV_W-1:0]    out_chosen_server
);

  state_t              state_r;
  state_t              state_nxt;
  logic [SRV_W-1:0]    cnt_r;
  logic [SRV_W-1:0]    last_idx;
  logic                op_r;
  logic [ID_W-1:0]     id_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [SRV_W-1:0]    given_r;
  logic [COST_W-1:0]   cost_r [NUM_SERVERS];
  logic [SRV_W-1:0]    chosen_r;
  logic [SRV_W-1:0]    target;
  logic                accept;

  assign accept = in_valid && in_ready;
  assign target = (op_r == OP_PLACE) ? stat.best_idx : given_r;

  // Last server scored: zero counts as one, too many clamps to the server count.
  always_comb begin
    if (servers_in_use == '0) begin
      last_idx = '0;
    end else if (servers_in_use >= SIU_W'(NUM_SERVERS)) begin
      last_idx = SRV_W'(NUM_SERVERS - 1);
    end else begin
      last_idx = SRV_W'(servers_in_use - 1'b1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == OP_PLACE) ? ST_SCORE : ST_COMMIT;
        end
      end
      ST_SCORE: begin
        if (cnt_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    req.clear     = 1'b0;
    req.issue     = 1'b0;
    req.idx       = cnt_r;
    req.comm      = cost_r[cnt_r];
    charge.en     = 1'b0;
    charge.idx    = target;
    charge.weight = weight_r;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        req.clear = 1'b1;
      end
      ST_SCORE:  req.issue = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: charge.en = 1'b1;
      ST_RESULT: out_valid = 1'b1;
      default:   ;
    endcase
  end

  // State and server counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_SCORE) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Request capture and chosen server.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      id_r     <= in_item_id;
      weight_r <= in_weight;
      given_r  <= in_given_server;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        cost_r[i] <= in_costs[i];
      end
    end
    if (state_r == ST_COMMIT) begin
      chosen_r <= target;
    end
  end

  assign weight            = weight_r;
  assign out_result_id     = id_r;
  assign out_chosen_server = chosen_r;

endmodule

[hdl/greedy_cost_makespan_assigner_top.sv]
// Top level of the greedy minimum-cost makespan assigner.
// A preload request adds its weight to the named server; a place request is scored on
// servers 0 to n-1 (n from servers_in_use, zero read as one, clamped to eight) and goes to
// the server with the lowest communication cost plus cost_factor times positive overload.
// One request is handled at a time. A preload goes from acceptance straight to the commit
// of its load and then to the result; a place request first issues one server per cycle
// into a shared three-stage scoring pipeline (slack, 32x24 multiply, compare), waits for
// the pipeline to drain and then commits the load. The block is ready
// again in the cycle after the result is taken. Loads and the reported makespan saturate
// at 2^40-1. Configuration must be written only while idle; the block itself does not enforce it.
module greedy_cost_makespan_assigner_top
  import gcma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [ID_W-1:0]       in_item_id,
  input  logic [WEIGHT_W-1:0]   in_weight,
  input  logic [SRV_W-1:0]      in_given_server,
  input  logic [COST_W-1:0]     in_cost_s0,
  input  logic [COST_W-1:0]     in_cost_s1,
  input  logic [COST_W-1:0]     in_cost_s2,
  input  logic [COST_W-1:0]     in_cost_s3,
  input  logic [COST_W-1:0]     in_cost_s4,
  input  logic [COST_W-1:0]     in_cost_s5,
  input  logic [COST_W-1:0]     in_cost_s6,
  input  logic [COST_W-1:0]     in_cost_s7,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       out_result_id,
  output logic [SRV_W-1:0]      out_chosen_server,
  output logic [LOAD_W-1:0]     out_makespan
);

  logic [SIU_W-1:0]    servers_in_use_r;
  logic [FACTOR_W-1:0] cost_factor_r;
  logic [COST_W-1:0]   costs [NUM_SERVERS];
  score_req_t          req;
  score_stat_t         stat;
  charge_t             charge;
  logic [WEIGHT_W-1:0] weight;
  logic [LOAD_W-1:0]   rd_load;
  logic [LOAD_W-1:0]   makespan;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servers_in_use_r <= SIU_RESET;
      cost_factor_r    <= FACTOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SERVERS_IN_USE: servers_in_use_r <= cfg_data[SIU_W-1:0];
        CFG_COST_FACTOR:    cost_factor_r    <= cfg_data[FACTOR_W-1:0];
        default:            ;
      endcase
    end
  end

  // Gather the per-server cost fields.
  always_comb begin
    costs[0] = in_cost_s0;
    costs[1] = in_cost_s1;
    costs[2] = in_cost_s2;
    costs[3] = in_cost_s3;
    costs[4] = in_cost_s4;
    costs[5] = in_cost_s5;
    costs[6] = in_cost_s6;
    costs[7] = in_cost_s7;
  end

  gcma_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_item_id        (in_item_id),
    .in_weight         (in_weight),
    .in_given_server   (in_given_server),
    .in_costs          (costs),
    .servers_in_use    (servers_in_use_r),
    .req               (req),
    .stat              (stat),
    .charge            (charge),
    .weight            (weight),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_id     (out_result_id),
    .out_chosen_server (out_chosen_server)
  );

  gcma_score_unit u_score (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .weight      (weight),
    .rd_load     (rd_load),
    .makespan    (makespan),
    .cost_factor (cost_factor_r),
    .stat        (stat)
  );

  gcma_load_file u_loads (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (req.idx),
    .rd_load  (rd_load),
    .charge   (charge),
    .makespan (makespan)
  );

  // The makespan register holds steady while the result waits.
  assign out_makespan = makespan;

endmodule

[dv/tb_greedy_cost_makespan_assigner_top.sv]
// Self-checking testbench for the greedy minimum-cost makespan assigner.
`timescale 1ns / 1ps

module tb_greedy_cost_makespan_assigner_top
  import gcma_pkg::*;
();

  localparam int unsigned PLAN_LEN          = 9;
  localparam int unsigned ITEMS_PER_SETTING = 130;
  localparam int unsigned HEAVY_COUNT       = 24;
  localparam int unsigned TAIL_ITEMS        = 40;
  localparam int unsigned HOLD_CYCLES       = 400;
  localparam int unsigned QUIET_LIMIT       = 3000;
  localparam int unsigned SETTLE_CYCLES     = 16;

  typedef logic [NUM_SERVERS-1:0][COST_W-1:0] cost_vec_t;

  typedef struct packed {
    logic                op;
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
    logic [SRV_W-1:0]    given;
    cost_vec_t           cost;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SRV_W-1:0]  server;
    logic [LOAD_W-1:0] span;
  } assignment_t;

  // One directed request; pinned rows carry a hand-written server and makespan.
  typedef struct packed {
    logic                op;
    logic [ID_W-1:0]     id;
    logic [WEIGHT_W-1:0] weight;
    logic [SRV_W-1:0]    given;
    cost_vec_t           cost;
    logic                pinned;
    logic [SRV_W-1:0]    pin_server;
    logic [LOAD_W-1:0]   pin_span;
  } stim_row_t;

  localparam cost_vec_t COSTS_ZERO = '0;
  localparam cost_vec_t COSTS_MAX  = '1;
  // Only server 5 is free of communication cost.
  localparam cost_vec_t COSTS_S5_FREE = {{2{24'hFFFFFF}}, 24'h000000, {5{24'hFFFFFF}}};
  // Server 0 is free; the rest cost the maximum.
  localparam cost_vec_t COSTS_S0_FREE = {{7{24'hFFFFFF}}, 24'h000000};
  localparam cost_vec_t COSTS_STRIPES = {4{24'hAAAAAA, 24'h555555}};
  localparam cost_vec_t COSTS_FLAT    = {8{24'h000100}};

  // Directed requests run from reset: eight servers, cost factor 1.0.
  localparam stim_row_t DIRECTED_ROWS [16] = '{
    '{OP_PLACE,   16'h0000, 24'h000000, 3'd0, COSTS_ZERO,    1'b1, 3'd0, 40'h0},
    '{OP_PRELOAD, 16'hFFFF, 24'hFFFFFF, 3'd7, COSTS_MAX,     1'b1, 3'd7, 40'hFF_FFFF},
    '{OP_PLACE,   16'h0002, 24'hFFFFFF, 3'd7, COSTS_MAX,     1'b1, 3'd0, 40'hFF_FFFF},
    '{OP_PRELOAD, 16'h0003, 24'h000001, 3'd3, COSTS_ZERO,    1'b1, 3'd3, 40'hFF_FFFF},
    '{OP_PLACE,   16'h0004, 24'h000010, 3'd0, COSTS_S5_FREE, 1'b1, 3'd5, 40'hFF_FFFF},
    '{OP_PLACE,   16'h0005, 24'hFFFFFF, 3'd0, COSTS_S0_FREE, 1'b0, 3'd0, 40'h0},
    '{OP_PRELOAD, 16'h0006, 24'h000000, 3'd0, COSTS_MAX,     1'b0, 3'd0, 40'h0},
    '{OP_PLACE,   16'h0007, 24'hFFFFFF, 3'd5, COSTS_ZERO,    1'b0, 3'd0, 40'h0},
    '{OP_PLACE,   16'h0008, 24'h000001, 3'd2, COSTS_MAX,     1'b0, 3'd0, 40'h0},
    '{OP_PRELOAD, 16'h5555, 24'hAAAAAA, 3'd1, COSTS_ZERO,    1'b0, 3'd0, 40'h0},
    '{OP_PRELOAD, 16'hAAAA, 24'h555555, 3'd2, COSTS_ZERO,    1'b0, 3'd0, 40'h0},
    '{OP_PRELOAD, 16'h1234, 24'h00FFFF, 3'd4, COSTS_ZERO,    1'b0, 3'd0, 40'h0},
    '{OP_PRELOAD, 16'h4321, 24'hFF0000, 3'd6, COSTS_ZERO,    1'b0, 3'd0, 40'h0},
    '{OP_PLACE,   16'h000D, 24'hFFFFFF, 3'd0, COSTS_ZERO,    1'b0, 3'd0, 40'h0},
    '{OP_PLACE,   16'h000E, 24'h800000, 3'd0, COSTS_STRIPES, 1'b0, 3'd0, 40'h0},
    '{OP_PLACE,   16'h000F, 24'h123456, 3'd0, COSTS_FLAT,    1'b0, 3'd0, 40'h0}
  };

  // Register settings walked by the random part, extremes included.
  localparam logic [SIU_W-1:0] SIU_PLAN [PLAN_LEN] = '{
    4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd8
  };
  localparam logic [FACTOR_W-1:0] FACTOR_PLAN [PLAN_LEN] = '{
    32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000,
    32'h0003_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0004_0000
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_operation;
  logic [ID_W-1:0]       in_item_id;
  logic [WEIGHT_W-1:0]   in_weight;
  logic [SRV_W-1:0]      in_given_server;
  logic [COST_W-1:0]     in_cost_s0;
  logic [COST_W-1:0]     in_cost_s1;
  logic [COST_W-1:0]     in_cost_s2;
  logic [COST_W-1:0]     in_cost_s3;
  logic [COST_W-1:0]     in_cost_s4;
  logic [COST_W-1:0]     in_cost_s5;
  logic [COST_W-1:0]     in_cost_s6;
  logic [COST_W-1:0]     in_cost_s7;
  logic                  out_valid;
  logic                  out_ready;
  logic [ID_W-1:0]       out_result_id;
  logic [SRV_W-1:0]      out_chosen_server;
  logic [LOAD_W-1:0]     out_makespan;

  // Shadow copy of the block's loads, makespan and registers.
  logic [LOAD_W-1:0]   srv_load [NUM_SERVERS];
  logic [LOAD_W-1:0]   span_q;
  logic [SIU_W-1:0]    servers_cfg;
  logic [FACTOR_W-1:0] factor_cfg;

  assignment_t pending_assignments [$];
  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_epoch;

  greedy_cost_makespan_assigner_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
    mismatches++;
  endtask

  // Scores every server in use for a place request, charges the chosen server and returns the expected result.
  function automatic assignment_t predict_assignment(input request_t r);
    assignment_t res;
    int unsigned n;
    int unsigned s;
    logic [63:0] slack;
    logic [63:0] cost;
    logic [63:0] best_cost;
    longint over;
    longint best_over;
    logic [SRV_W-1:0] pick;
    logic [LOAD_W:0] sum;
    pick = r.given;
    if (r.op == OP_PLACE) begin
      n = (servers_cfg == 0) ? 1 : (servers_cfg > NUM_SERVERS) ? NUM_SERVERS : servers_cfg;
      best_cost = '0;
      best_over = 0;
      pick = '0;
      for (s = 0; s < n; s++) begin
        slack = 64'(span_q - srv_load[s]);
        over = longint'(r.weight) - longint'(slack);
        cost = {24'b0, r.cost[s], 16'b0};
        // Only a positive overload adds the makespan penalty.
        if (over > 0) begin
          cost = cost + {32'b0, factor_cfg} * over[63:0];
        end
        if (s == 0 || cost < best_cost || (cost == best_cost && over < best_over)) begin
          best_cost = cost;
          best_over = over;
          pick = SRV_W'(s);
        end
      end
    end
    // Saturating load update; the makespan rises to the charged server's load when that is larger.
    sum = {1'b0, srv_load[pick]} + {17'b0, r.weight};
    srv_load[pick] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    if (srv_load[pick] > span_q) begin
      span_q = srv_load[pick];
    end
    res.id = r.id;
    res.server = pick;
    res.span = span_q;
    return res;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned s;
    int unsigned wsel;
    int unsigned csel;
    r.op = ($urandom_range(99) < 75) ? OP_PLACE : OP_PRELOAD;
    r.id = ID_W'($urandom());
    r.given = SRV_W'($urandom());
    wsel = $urandom_range(9);
    case (wsel)
      0: r.weight = '0;
      1: r.weight = '1;
      2, 3, 4: r.weight = WEIGHT_W'($urandom_range(4095));
      5, 6: r.weight = WEIGHT_W'($urandom_range(262143));
      default: r.weight = WEIGHT_W'($urandom());
    endcase
    // Small and near-equal costs keep the overload and tie rules in play.
    csel = $urandom_range(3);
    for (s = 0; s < NUM_SERVERS; s++) begin
      case (csel)
        0: r.cost[s] = COST_W'($urandom());
        1: r.cost[s] = COST_W'($urandom_range(4095));
        2: r.cost[s] = COST_W'($urandom_range(1));
        default: r.cost[s] = COST_W'($urandom_range(262143));
      endcase
    end
    return r;
  endfunction

  // Offers one request and records its expected result once it is taken.
  // Valid is left high so that the next request can follow without a gap.
  task automatic send_request(input request_t r, input logic pinned,
                              input logic [SRV_W-1:0] pin_server,
                              input logic [LOAD_W-1:0] pin_span);
    int unsigned gap;
    assignment_t want;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(8, 1);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= r.op;
    in_item_id      <= r.id;
    in_weight       <= r.weight;
    in_given_server <= r.given;
    in_cost_s0      <= r.cost[0];
    in_cost_s1      <= r.cost[1];
    in_cost_s2      <= r.cost[2];
    in_cost_s3      <= r.cost[3];
    in_cost_s4      <= r.cost[4];
    in_cost_s5      <= r.cost[5];
    in_cost_s6      <= r.cost[6];
    in_cost_s7      <= r.cost[7];
    do @(posedge clk); while (!in_ready);
    want = predict_assignment(r);
    if (pinned) begin
      want.server = pin_server;
      want.span = pin_span;
    end
    pending_assignments.push_back(want);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SERVERS_IN_USE) begin
      servers_cfg = data[SIU_W-1:0];
    end else begin
      factor_cfg = data;
    end
  endtask

  task automatic apply_setting(input logic [SIU_W-1:0] siu, input logic [FACTOR_W-1:0] factor);
    write_register(CFG_SERVERS_IN_USE, CFG_DATA_W'(siu));
    write_register(CFG_COST_FACTOR, factor);
    cfg_valid <= 1'b0;
  endtask

  // Always advances time, so a request may be raised right after it returns.
  task automatic wait_drained();
    do @(posedge clk); while (pending_assignments.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever the epoch moves.
  initial begin
    int unsigned seen_epoch;
    int unsigned stall_left;
    seen_epoch = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_epoch != seen_epoch) begin
        seen_epoch = hold_epoch;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compares every taken result with the oldest expectation.
  always @(posedge clk) begin : result_check
    assignment_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_assignments.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(out_result_id), 64'(0));
      end else begin
        want = pending_assignments.pop_front();
        if (out_result_id !== want.id) begin
          report_mismatch("result_id", 64'(out_result_id), 64'(want.id));
        end
        if (out_chosen_server !== want.server) begin
          report_mismatch("chosen_server", 64'(out_chosen_server), 64'(want.server));
        end
        if (out_makespan !== want.span) begin
          report_mismatch("makespan", 64'(out_makespan), 64'(want.span));
        end
      end
    end
  end

  // Ends the run when no channel has moved for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    request_t req;
    int unsigned i;
    int unsigned p;
    int unsigned k;
    mismatches = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_epoch = 0;
    for (i = 0; i < NUM_SERVERS; i++) begin
      srv_load[i] = '0;
    end
    span_q = '0;
    servers_cfg = SIU_RESET;
    factor_cfg = FACTOR_RESET;
    rst_n           <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_SERVERS_IN_USE;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    in_operation    <= OP_PRELOAD;
    in_item_id      <= '0;
    in_weight       <= '0;
    in_given_server <= '0;
    in_cost_s0      <= '0;
    in_cost_s1      <= '0;
    in_cost_s2      <= '0;
    in_cost_s3      <= '0;
    in_cost_s4      <= '0;
    in_cost_s5      <= '0;
    in_cost_s6      <= '0;
    in_cost_s7      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests from the reset state.
    for (i = 0; i < $size(DIRECTED_ROWS); i++) begin
      req.op = DIRECTED_ROWS[i].op;
      req.id = DIRECTED_ROWS[i].id;
      req.weight = DIRECTED_ROWS[i].weight;
      req.given = DIRECTED_ROWS[i].given;
      req.cost = DIRECTED_ROWS[i].cost;
      send_request(req, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].pin_server,
                   DIRECTED_ROWS[i].pin_span);
    end
    in_valid <= 1'b0;
    wait_drained();

    // Random requests under each register setting and idling mode.
    for (p = 0; p < PLAN_LEN; p++) begin
      apply_setting(SIU_PLAN[p], FACTOR_PLAN[p]);
      if (p < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 69;
      end else if (p < 6) begin
        send_idle_pct = 69;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (k = 0; k < ITEMS_PER_SETTING; k++) begin
        // Long receiver hold-off while the sender keeps offering.
        if (p == 1 && k == ITEMS_PER_SETTING / 2) begin
          hold_epoch++;
        end
        // Sender pauses until every result is back.
        if (p == 4 && k == ITEMS_PER_SETTING / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_request(random_request(), 1'b0, '0, '0);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    // Stack maximum-weight preloads on server 0, then send random requests on top of it.
    apply_setting(4'd2, FACTOR_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < HEAVY_COUNT; i++) begin
      req = random_request();
      req.op = OP_PRELOAD;
      req.id = ID_W'(i);
      req.weight = '1;
      req.given = '0;
      send_request(req, 1'b0, '0, '0);
    end
    for (i = 0; i < TAIL_ITEMS; i++) begin
      send_request(random_request(), 1'b0, '0, '0);
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
